[hw/rtl/fwr_pkg.sv]
package fwr_pkg;

   // Field widths of one item
   localparam int FUNC_W   = 2;
   localparam int ID_W     = 22;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default queue depth
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [FUNC_W-1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_REM = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Per-cell command
   typedef struct packed {
      logic load;    // take the new identifier
      logic shift;   // take the right neighbor's identifier
   } cell_ctrl_type;

endpackage

[hw/rtl/fwr_if.sv]
interface fwr_req_if;
   logic                         valid;
   logic                         ready;
   logic [fwr_pkg::FUNC_W-1:0]   func;
   logic [fwr_pkg::ID_W-1:0]     item_id;

   modport source (output valid, output func, output item_id, input ready);
   modport sink   (input valid, input func, input item_id, output ready);
endinterface

interface fwr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fwr_pkg::STATUS_W-1:0] status;
   logic [fwr_pkg::ID_W-1:0]     head_id;
   logic                         now_empty;
   logic [fwr_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output head_id, output now_empty,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input head_id, input now_empty,
                   input entry_count, output ready);
endinterface

[hw/rtl/fwr_cell.sv]
module fwr_cell (
   input  logic                       clock,
   input  fwr_pkg::cell_ctrl_type     ctrl,
   input  logic [fwr_pkg::ID_W-1:0]   new_id,
   input  logic [fwr_pkg::ID_W-1:0]   right_id,
   input  logic [fwr_pkg::ID_W-1:0]   key_id,
   output logic [fwr_pkg::ID_W-1:0]   cell_id,
   output logic                       cell_match
);

   logic [fwr_pkg::ID_W-1:0] id_ff;
   logic [fwr_pkg::ID_W-1:0] id_in;

   // Select load, shift from neighbor, or hold
   always_comb begin
      id_in = id_ff;
      if (ctrl.load) begin
         id_in = new_id;
      end else if (ctrl.shift) begin
         id_in = right_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign cell_id    = id_ff;
   assign cell_match = (id_ff == key_id);

endmodule

[hw/rtl/fifo_with_remove_by_id.sv]
// Channel  Dir  Payload                                       Accepted when
// req      in   func, item_id                                 req.valid && req.ready
// rsp      out  status, head_id, now_empty, entry_count       rsp.valid && rsp.ready
//
// Enqueue, dequeue and unused codes finish in execute once the output register is free:
// the result is registered and the sequencer returns to idle to take the next item.
// Remove examines one cell per cycle with the scan counter while the output register is
// free, up to the first match or the last entry (no cell is examined when empty).
// A new item is accepted while a finished result waits in the output register.
// Reset (synchronous) empties the queue; cell contents are not cleared.
module fifo_with_remove_by_id #(
   parameter int DEPTH = fwr_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fwr_req_if.sink     req,
   fwr_rsp_if.source   rsp
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = CW + 1;
   localparam int XW = CW + fwr_pkg::COUNT_W;

   fwr_pkg::state_type state_ff, state_in;
   fwr_pkg::op_type    op_ff, op_in;
   logic [fwr_pkg::ID_W-1:0] key_ff, key_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            scan_ff, scan_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   fwr_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [fwr_pkg::ID_W-1:0]      rsp_head_ff, rsp_head_in;
   logic                          rsp_empty_ff, rsp_empty_in;
   logic [fwr_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   fwr_pkg::cell_ctrl_type   ctrl [DEPTH];
   logic [fwr_pkg::ID_W-1:0] cell_id [DEPTH];
   logic [DEPTH-1:0]         match_vec;
   logic                     shift_all;
   logic                     shift_from;
   logic                     load_tail;
   logic                     finish;
   logic [XW-1:0]            count_wide;

   // Row of cells; each takes its right neighbor on a shift, the last one keeps its own
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [fwr_pkg::ID_W-1:0] right_id;
      if (g == DEPTH - 1) begin : g_last
         assign right_id = cell_id[g];
      end else begin : g_mid
         assign right_id = cell_id[g+1];
      end
      fwr_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .new_id     (key_ff),
         .right_id   (right_id),
         .key_id     (key_ff),
         .cell_id    (cell_id[g]),
         .cell_match (match_vec[g])
      );
   end

   // Decode cell commands from the shared control
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].load  = load_tail && (count_ff == CW'(i));
         ctrl[i].shift = shift_all || (shift_from && (IW'(i) >= scan_ff));
      end
   end

   assign req.ready = (state_ff == fwr_pkg::S_IDLE);

   // Sequence one operation and build its result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_head_in   = rsp_head_ff;
      load_tail     = 1'b0;
      shift_all     = 1'b0;
      shift_from    = 1'b0;
      finish        = 1'b0;
      case (state_ff)
         fwr_pkg::S_IDLE: begin
            if (req.valid) begin
               op_in    = fwr_pkg::op_type'(req.func);
               key_in   = req.item_id;
               scan_in  = '0;
               state_in = fwr_pkg::S_EXEC;
            end
         end
         fwr_pkg::S_EXEC: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_status_in = fwr_pkg::ST_OK;
               rsp_head_in   = '0;
               case (op_ff)
                  fwr_pkg::OP_ENQ: begin
                     finish = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = fwr_pkg::ST_FULL;
                     end else begin
                        load_tail = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  fwr_pkg::OP_DEQ: begin
                     finish = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = fwr_pkg::ST_EMPTY;
                     end else begin
                        rsp_head_in = cell_id[0];
                        shift_all   = 1'b1;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  fwr_pkg::OP_REM: begin
                     if (CW'(scan_ff) >= count_ff) begin
                        finish        = 1'b1;
                        rsp_status_in = fwr_pkg::ST_NOTFOUND;
                     end else if (match_vec[scan_ff]) begin
                        finish     = 1'b1;
                        shift_from = 1'b1;
                        count_in   = count_ff - CW'(1);
                     end else if (WW'(scan_ff) + WW'(1) >= WW'(count_ff)) begin
                        finish        = 1'b1;
                        rsp_status_in = fwr_pkg::ST_NOTFOUND;
                     end else begin
                        scan_in = scan_ff + IW'(1);
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
               if (finish) begin
                  rsp_valid_in = 1'b1;
                  state_in     = fwr_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = fwr_pkg::S_IDLE;
         end
      endcase
   end

   assign count_wide   = XW'(count_in);
   assign rsp_empty_in = finish ? (count_in == '0) : rsp_empty_ff;
   assign rsp_count_in = finish ? count_wide[fwr_pkg::COUNT_W-1:0] : rsp_count_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwr_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      scan_ff       <= scan_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.head_id     = rsp_head_ff;
   assign rsp.now_empty   = rsp_empty_ff;
   assign rsp.entry_count = rsp_count_ff;

   // Occupancy never exceeds the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // An accepted item always moves the sequencer to execute
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == fwr_pkg::S_EXEC))
      else $error("accepted item not executed");

   // A successful enqueue grows the queue by one
   a_enq_grow: assert property (@(posedge clock) disable iff (reset)
      (load_tail) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("enqueue count mismatch");

   // An empty-dequeue result reports an empty queue
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == fwr_pkg::ST_EMPTY) |-> rsp_empty_ff)
      else $error("empty status without empty flag");

endmodule
